FILE: design/hdamp_pkg.sv
// Shared types, register indexes and the stride table of the prefetcher.
package hdamp_pkg;

   typedef struct packed {
      logic clear;
      logic latch;
      logic pscan;
      logic psel;
      logic pload;
      logic cscan;
      logic csel;
      logic cload;
      logic dstep;
      logic mstep;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic scan_done;
      logic delta_go;
      logic delta_done;
      logic delta_any;
      logic map_done;
   } status_type;

   typedef struct packed {
      logic [35:0] tag;
      logic [63:0] amap;
      logic [63:0] pmap;
      logic [31:0] age;
   } page_row_type;

   localparam logic [2:0] CSR_MSHR_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_STRIDE_COUNT   = 3'd1;
   localparam logic [2:0] CSR_ACTIVE_PAGES   = 3'd2;
   localparam logic [2:0] CSR_MAP_DEGREE     = 3'd3;
   localparam logic [2:0] CSR_DELTA_DEGREE   = 3'd4;

   function automatic logic [3:0] stride_of(input logic [2:0] k);
      logic [3:0] s;
      unique case (k)
         3'd0: s = 4'd1;
         3'd1: s = 4'd2;
         3'd2: s = 4'd3;
         3'd3: s = 4'd4;
         3'd4: s = 4'd6;
         default: s = 4'd8;
      endcase
      return s;
   endfunction

endpackage

FILE: design/hdamp_ctrl.sv
// Sequencer that steps the datapath through lookup, prediction and writeback.
module hdamp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  hdamp_pkg::status_type status,
   output hdamp_pkg::cmd_type    cmd,
   output logic                  idle
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_PSCAN, S_PSEL, S_PLOAD, S_CSCAN, S_CSEL, S_CLOAD,
      S_DELTA, S_MAP, S_FIN
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         unique case (state_ff)
            S_CLEAR: if (status.clr_done) state_ff <= S_IDLE;
            S_IDLE:  if (start) state_ff <= S_PSCAN;
            S_PSCAN: if (status.scan_done) state_ff <= S_PSEL;
            S_PSEL:  state_ff <= S_PLOAD;
            S_PLOAD: state_ff <= S_CSCAN;
            S_CSCAN: if (status.scan_done) state_ff <= S_CSEL;
            S_CSEL:  state_ff <= S_CLOAD;
            S_CLOAD: state_ff <= status.delta_go ? S_DELTA : S_MAP;
            S_DELTA: begin
               if (status.delta_done) state_ff <= status.delta_any ? S_FIN : S_MAP;
            end
            S_MAP:   if (status.map_done) state_ff <= S_FIN;
            S_FIN:   state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.clear  = (state_ff == S_CLEAR);
      cmd.latch  = (state_ff == S_IDLE) && start;
      cmd.pscan  = (state_ff == S_PSCAN);
      cmd.psel   = (state_ff == S_PSEL);
      cmd.pload  = (state_ff == S_PLOAD);
      cmd.cscan  = (state_ff == S_CSCAN);
      cmd.csel   = (state_ff == S_CSEL);
      cmd.cload  = (state_ff == S_CLOAD);
      cmd.dstep  = (state_ff == S_DELTA);
      cmd.mstep  = (state_ff == S_MAP);
      cmd.finish = (state_ff == S_FIN);
   end

   assign idle = (state_ff == S_IDLE);

endmodule

FILE: design/hdamp_datapath.sv
// Page and PC tables, delta replay and access-map stride matching.
module hdamp_datapath #(
   parameter int PAGE_ENTRIES = 512,
   parameter int PC_ENTRIES   = 256,
   parameter int DELTA_DEPTH  = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hdamp_pkg::cmd_type    cmd,
   output hdamp_pkg::status_type status,
   input  logic [47:0]           req_access_address,
   input  logic [47:0]           req_instr_pointer,
   input  logic [4:0]            req_mshr_occupancy,
   input  logic                  csr_wr,
   input  logic [2:0]            csr_index,
   input  logic [9:0]            csr_data,
   output logic                  rsp_valid,
   output logic [47:0]           rsp_prefetch_address,
   output logic                  rsp_to_llc,
   output logic                  rsp_from_map,
   output logic                  rsp_last_of_run
);

   localparam int PAW = $clog2(PAGE_ENTRIES);
   localparam int PCW = $clog2(PC_ENTRIES);
   localparam int SCW = ((PAW > PCW) ? PAW : PCW) + 1;
   localparam int JW  = $clog2(DELTA_DEPTH);

   typedef struct packed {
      logic [47:0]                  tag;
      logic [47:0]                  last;
      logic [47:0]                  lpf;
      logic [31:0]                  age;
      logic [DELTA_DEPTH-1:0][31:0] dl;
   } pc_row_type;

   hdamp_pkg::page_row_type pmem [PAGE_ENTRIES];
   pc_row_type              cmem [PC_ENTRIES];
   hdamp_pkg::page_row_type prd_ff;
   pc_row_type              crd_ff;
   logic [PAW-1:0]          prd_addr;
   logic [PCW-1:0]          crd_addr;

   logic [4:0]  thr_ff;
   logic [2:0]  strc_ff;
   logic [9:0]  actp_ff;
   logic [2:0]  mdegc_ff;
   logic [3:0]  ddegc_ff;

   logic [47:0] addr_ff, ip_ff;
   logic        llc_ff;
   logic [31:0] clk_ff;

   logic [SCW-1:0] cnt_ff;
   logic           lag_ff;
   logic [SCW-2:0] lag_idx_ff;

   logic           phit_ff;
   logic [PAW-1:0] pidx_ff, pbest_ff;
   logic [31:0]    pmin_ff;
   logic [63:0]    amap_ff, pmap_ff;

   logic           chit_ff, cinv_ff;
   logic [PCW-1:0] cidx_ff, cinvidx_ff, cbest_ff, eidx_ff;
   logic [31:0]    cmin_ff;
   logic [PC_ENTRIES-1:0] pcv_ff;
   pc_row_type     crow_ff;

   logic [JW-1:0]  j_ff;
   logic           jvld_ff;
   logic [47:0]    acc_ff;
   logic [3:0]     n_ff;

   logic [2:0]     k_ff, mcnt_ff;
   logic           dir_ff;

   logic           pend_vld_ff, pend_map_ff;
   logic [47:0]    pend_addr_ff;
   logic           rsp_valid_ff, rsp_map_ff, rsp_last_ff;
   logic [47:0]    rsp_addr_ff;

   // effective register values
   logic [10:0]    ap11;
   logic [SCW-1:0] npages, lim;
   logic [2:0]     nstr, mdeg;
   logic [3:0]     ddeg;

   always_comb begin
      ap11 = {1'b0, actp_ff};
      if (ap11 == 11'd0) npages = SCW'(1);
      else if (ap11 > 11'(PAGE_ENTRIES)) npages = SCW'(PAGE_ENTRIES);
      else npages = SCW'(ap11);
      lim  = cmd.pscan ? npages : SCW'(PC_ENTRIES);
      nstr = (strc_ff == 3'd0) ? 3'd1 : ((strc_ff > 3'd6) ? 3'd6 : strc_ff);
      mdeg = (mdegc_ff == 3'd0) ? 3'd1 : ((mdegc_ff > 3'd4) ? 3'd4 : mdegc_ff);
      ddeg = (ddegc_ff == 4'd0) ? 4'd1 : ((ddegc_ff > 4'd8) ? 4'd8 : ddegc_ff);
   end

   logic [35:0] page;
   logic [5:0]  off;
   assign page = addr_ff[47:12];
   assign off  = addr_ff[11:6];

   // PC row update on load: shift in the new delta, find an older copy of the pair
   logic [31:0]                  nd;
   logic [DELTA_DEPTH-1:0][31:0] ns;
   logic                         mfound, diff;
   logic [JW-1:0]                midx;

   always_comb begin
      nd = 32'(addr_ff - crd_ff.last);
      ns[0] = nd;
      for (int i = 1; i < DELTA_DEPTH; i++) ns[i] = crd_ff.dl[i-1];
      mfound = 1'b0;
      midx   = '0;
      for (int i = DELTA_DEPTH - 2; i >= 2; i--) begin
         if (ns[i] == ns[0] && ns[i+1] == ns[1]) begin
            mfound = 1'b1;
            midx   = JW'(i - 1);
         end
      end
      diff = (addr_ff != crd_ff.last);
   end

   // delta replay step
   logic [31:0] dsel;
   logic [47:0] anew;
   logic [5:0]  dpi;
   logic        ddone, dact, dpass;

   always_comb begin
      dsel  = crow_ff.dl[j_ff];
      anew  = acc_ff + {{16{dsel[31]}}, dsel};
      dpi   = anew[11:6];
      ddone = !jvld_ff || (n_ff >= ddeg);
      dact  = cmd.dstep && !ddone;
      dpass = (dsel != 32'd0) && (anew[47:12] == page) && !amap_ff[dpi] &&
              !pmap_ff[dpi] && (anew != crow_ff.lpf);
   end

   // map stride step
   logic [6:0] o7, s7, tt, sa, sb;
   logic       mstop, mact;

   always_comb begin
      o7 = {1'b0, off};
      s7 = {3'b000, hdamp_pkg::stride_of(k_ff)};
      if (!dir_ff) begin
         mstop = (k_ff >= nstr) || (o7 < (s7 << 1)) || (o7 + s7 > 7'd63) ||
                 (mcnt_ff >= mdeg);
         tt = o7 + s7;
         sa = o7 - s7;
         sb = o7 - (s7 << 1);
      end else begin
         mstop = (k_ff >= nstr) || (o7 + (s7 << 1) > 7'd63) || (o7 < s7) ||
                 (mcnt_ff >= mdeg);
         tt = o7 - s7;
         sa = o7 + s7;
         sb = o7 + (s7 << 1);
      end
      mact = cmd.mstep && !mstop && !amap_ff[tt[5:0]] && !pmap_ff[tt[5:0]] &&
             amap_ff[sa[5:0]] && amap_ff[sb[5:0]];
   end

   logic        emit, emit_map;
   logic [47:0] emit_addr;
   assign emit      = (dact && dpass) || mact;
   assign emit_map  = mact;
   assign emit_addr = mact ? {page, tt[5:0], 6'd0} : anew;

   always_comb begin
      status            = '0;
      status.clr_done   = (cnt_ff == SCW'(PAGE_ENTRIES - 1));
      status.scan_done  = (cnt_ff >= lim) && !lag_ff;
      status.delta_go   = chit_ff && diff && mfound;
      status.delta_done = ddone;
      status.delta_any  = (n_ff != 4'd0);
      status.map_done   = dir_ff && mstop;
   end

   assign prd_addr = cmd.psel ? (phit_ff ? pidx_ff : pbest_ff) : cnt_ff[PAW-1:0];
   assign crd_addr = cmd.csel ? (chit_ff ? cidx_ff : (cinv_ff ? cinvidx_ff : cbest_ff))
                              : cnt_ff[PCW-1:0];

   // memories
   always_ff @(posedge clock) begin
      prd_ff <= pmem[prd_addr];
      crd_ff <= cmem[crd_addr];
      if (cmd.clear) pmem[cnt_ff[PAW-1:0]] <= '0;
      else if (cmd.finish) pmem[pidx_ff] <= {page, amap_ff, pmap_ff, clk_ff};
      if (cmd.finish) cmem[eidx_ff] <= crow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= 5'd8;
         strc_ff      <= 3'd4;
         actp_ff      <= 10'd512;
         mdegc_ff     <= 3'd2;
         ddegc_ff     <= 4'd4;
         clk_ff       <= '0;
         cnt_ff       <= '0;
         lag_ff       <= 1'b0;
         pcv_ff       <= '0;
         jvld_ff      <= 1'b0;
         n_ff         <= '0;
         k_ff         <= '0;
         mcnt_ff      <= '0;
         dir_ff       <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (csr_index)
               hdamp_pkg::CSR_MSHR_THRESHOLD: thr_ff   <= csr_data[4:0];
               hdamp_pkg::CSR_STRIDE_COUNT:   strc_ff  <= csr_data[2:0];
               hdamp_pkg::CSR_ACTIVE_PAGES:   actp_ff  <= csr_data;
               hdamp_pkg::CSR_MAP_DEGREE:     mdegc_ff <= csr_data[2:0];
               hdamp_pkg::CSR_DELTA_DEGREE:   ddegc_ff <= csr_data[3:0];
               default: ;
            endcase
         end

         // shared scan counter
         if (cmd.latch || cmd.psel) begin
            cnt_ff <= '0;
            lag_ff <= 1'b0;
         end else if (cmd.pscan || cmd.cscan) begin
            if (cnt_ff < lim) begin
               lag_ff     <= 1'b1;
               lag_idx_ff <= cnt_ff[SCW-2:0];
               cnt_ff     <= cnt_ff + 1'b1;
            end else begin
               lag_ff <= 1'b0;
            end
         end else if (cmd.clear) begin
            cnt_ff <= cnt_ff + 1'b1;
         end

         if (cmd.latch) begin
            addr_ff <= req_access_address;
            ip_ff   <= req_instr_pointer;
            llc_ff  <= (req_mshr_occupancy >= thr_ff);
            clk_ff  <= clk_ff + 1'b1;
            phit_ff <= 1'b0;
         end

         // page search: first tag hit, first oldest entry
         if (cmd.pscan && lag_ff) begin
            if (!phit_ff && prd_ff.tag == page) begin
               phit_ff <= 1'b1;
               pidx_ff <= lag_idx_ff[PAW-1:0];
            end
            if (lag_idx_ff == '0 || prd_ff.age < pmin_ff) begin
               pmin_ff  <= prd_ff.age;
               pbest_ff <= lag_idx_ff[PAW-1:0];
            end
         end

         if (cmd.psel) begin
            pidx_ff <= phit_ff ? pidx_ff : pbest_ff;
            chit_ff <= 1'b0;
            cinv_ff <= 1'b0;
         end

         if (cmd.pload) begin
            amap_ff <= (phit_ff ? prd_ff.amap : 64'd0) | (64'd1 << off);
            pmap_ff <= phit_ff ? prd_ff.pmap : 64'd0;
         end

         // PC search: first valid hit, first free entry, first oldest entry
         if (cmd.cscan && lag_ff) begin
            if (pcv_ff[lag_idx_ff[PCW-1:0]] && !chit_ff && crd_ff.tag == ip_ff) begin
               chit_ff <= 1'b1;
               cidx_ff <= lag_idx_ff[PCW-1:0];
            end
            if (!pcv_ff[lag_idx_ff[PCW-1:0]] && !cinv_ff) begin
               cinv_ff    <= 1'b1;
               cinvidx_ff <= lag_idx_ff[PCW-1:0];
            end
            if (lag_idx_ff == '0 || crd_ff.age < cmin_ff) begin
               cmin_ff  <= crd_ff.age;
               cbest_ff <= lag_idx_ff[PCW-1:0];
            end
         end

         if (cmd.csel) eidx_ff <= crd_addr;

         if (cmd.cload) begin
            k_ff    <= '0;
            mcnt_ff <= '0;
            dir_ff  <= 1'b0;
            n_ff    <= '0;
            jvld_ff <= chit_ff && diff && mfound;
            acc_ff  <= addr_ff;
            j_ff    <= midx;
            if (!chit_ff) begin
               crow_ff <= {ip_ff, addr_ff, 48'd0, clk_ff, {DELTA_DEPTH{32'd0}}};
            end else if (!diff) begin
               crow_ff <= {crd_ff.tag, crd_ff.last, crd_ff.lpf, clk_ff, crd_ff.dl};
            end else begin
               crow_ff <= {crd_ff.tag, addr_ff, crd_ff.lpf, clk_ff, ns};
            end
         end

         if (dact) begin
            if (j_ff == '0) jvld_ff <= 1'b0;
            else j_ff <= j_ff - 1'b1;
            if (dsel != 32'd0) begin
               acc_ff <= anew;
               if (dpass) begin
                  crow_ff.lpf  <= anew;
                  pmap_ff[dpi] <= 1'b1;
                  n_ff         <= n_ff + 1'b1;
               end
            end
         end

         if (cmd.mstep) begin
            if (mstop) begin
               if (!dir_ff) begin
                  dir_ff  <= 1'b1;
                  k_ff    <= '0;
                  mcnt_ff <= '0;
               end
            end else begin
               k_ff <= k_ff + 1'b1;
               if (mact) begin
                  pmap_ff[tt[5:0]] <= 1'b1;
                  mcnt_ff          <= mcnt_ff + 1'b1;
               end
            end
         end

         if (cmd.finish) pcv_ff[eidx_ff] <= 1'b1;

         // hold one result back so the last one can be marked
         if (cmd.finish) begin
            rsp_valid_ff <= pend_vld_ff;
            rsp_addr_ff  <= pend_addr_ff;
            rsp_map_ff   <= pend_map_ff;
            rsp_last_ff  <= 1'b1;
            pend_vld_ff  <= 1'b0;
         end else if (emit) begin
            rsp_valid_ff <= pend_vld_ff;
            rsp_addr_ff  <= pend_addr_ff;
            rsp_map_ff   <= pend_map_ff;
            rsp_last_ff  <= 1'b0;
            pend_vld_ff  <= 1'b1;
            pend_addr_ff <= emit_addr;
            pend_map_ff  <= emit_map;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_prefetch_address = rsp_addr_ff;
   assign rsp_to_llc           = llc_ff;
   assign rsp_from_map         = rsp_map_ff;
   assign rsp_last_of_run      = rsp_last_ff;

   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !pend_vld_ff)
      else $error("held beat survives run end");

   a_delta_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= 4'd8)
      else $error("delta count over limit");

   a_map_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.mstep |-> mcnt_ff <= mdeg)
      else $error("map count over degree");

endmodule

FILE: design/hybrid_delta_access_map_prefetcher.sv
// Top level: hybrid delta-correlation and access-map L2 prefetcher.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  req     | start & !busy         | access_address, instr_pointer, mshr_occ
//  rsp     | rsp_valid (one cycle) | prefetch_address, to_llc, from_map, last
//  csr     | csr_valid & csr_ready | csr_index, csr_data
//
//  Busy from the accepting edge through the page table search over the
//  active_pages entries (clamped to 1..PAGE_ENTRIES) and the PC table
//  search over PC_ENTRIES entries, one entry a cycle, the row loads, delta
//  replay, or stride matching when no delta beat goes out, the writeback
//  and the time the last beat is out. Beats leave at most one per cycle.
//  After reset the page memory is cleared, with busy high.
//  Results cannot be stalled; each rsp beat is lost if not taken that cycle.
module hybrid_delta_access_map_prefetcher #(
   parameter int PAGE_ENTRIES = 512,
   parameter int PC_ENTRIES   = 256,
   parameter int DELTA_DEPTH  = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [47:0] req_access_address,
   input  logic [47:0] req_instr_pointer,
   input  logic [4:0]  req_mshr_occupancy,
   output logic        rsp_valid,
   output logic [47:0] rsp_prefetch_address,
   output logic        rsp_to_llc,
   output logic        rsp_from_map,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_data
);

   hdamp_pkg::cmd_type    cmd;
   hdamp_pkg::status_type status;
   logic                  idle;

   hdamp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start && !busy),
      .status (status),
      .cmd    (cmd),
      .idle   (idle)
   );

   hdamp_datapath #(
      .PAGE_ENTRIES (PAGE_ENTRIES),
      .PC_ENTRIES   (PC_ENTRIES),
      .DELTA_DEPTH  (DELTA_DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_access_address   (req_access_address),
      .req_instr_pointer    (req_instr_pointer),
      .req_mshr_occupancy   (req_mshr_occupancy),
      .csr_wr               (csr_valid && csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_valid            (rsp_valid),
      .rsp_prefetch_address (rsp_prefetch_address),
      .rsp_to_llc           (rsp_to_llc),
      .rsp_from_map         (rsp_from_map),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   // stay busy until the final beat has gone out
   assign busy      = !idle || rsp_valid;
   assign csr_ready = 1'b1;

endmodule
